/* rtl/core/piece_table_edit_engine_core_defines.svh */
// Assertion macros shared by the piece table edit engine.
// Depends on nothing; included by modules that carry assertions.
`ifndef PIECE_TABLE_EDIT_ENGINE_CORE_DEFINES_SVH
`define PIECE_TABLE_EDIT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/pte_pkg.sv */
// Shared types and constants of the piece table edit engine.
// Depends on nothing; used by piece_table_edit_engine_core (pte_ram does not use it).
package pte_pkg;

  localparam int MAX_PIECES = 64;
  localparam int POS_BITS   = 24;
  localparam int IDX_W      = $clog2(MAX_PIECES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SUM_W      = POS_BITS + CNT_W;
  localparam int PIDX_W     = 6;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_RANGE  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_BADIDX = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] len;
  } piece_t;

endpackage

/* rtl/core/pte_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module pte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/piece_table_edit_engine_core.sv */
// Piece table edit engine: an ordered table of text pieces held in one RAM.
// A read looks up one entry; an insert scans up to the covering piece, then the tail is
// moved, and a remove scans the whole table before a split or a compaction pass.
// One request at a time: busy stays high until the result beat is shown and is low during it.
// Reset (rst_n low, synchronous) empties the table; the RAM is not cleared.
// Results are shown for one cycle on out_valid and cannot be held off.
`include "piece_table_edit_engine_core_defines.svh"
module piece_table_edit_engine_core
  import pte_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_req_type,
  input  logic [POS_BITS-1:0] in_doc_position,
  input  logic                in_buffer_kind,
  input  logic [POS_BITS-1:0] in_piece_start,
  input  logic [POS_BITS-1:0] in_run_length,
  input  logic [PIDX_W-1:0]   in_piece_index,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [CNT_W-1:0]    out_piece_total,
  output logic                out_kind,
  output logic [POS_BITS-1:0] out_start,
  output logic [POS_BITS-1:0] out_length
);

  // The sequencer walks the table through the RAM's read port one entry a
  // cycle, with the read data arriving in the next cycle tagged by its index.
  // An insert first scans for the covering piece, then opens needed slots by moving
  // the tail upwards (highest entry first, so nothing unread is overwritten),
  // and finally writes up to three fresh entries. A remove first sums the
  // document length and looks for a span strictly inside one piece; that
  // split case is handled like an insert, every other valid non-empty remove is an
  // in-place compaction pass where the write index never overtakes the read index.
  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_ISSUE, ST_RD_DATA, ST_SCAN, ST_DECIDE, ST_SHIFT, ST_FIX, ST_COMPACT
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic                kind_r, kind_nxt;
  logic [POS_BITS-1:0] nstart_r, nstart_nxt;
  logic [POS_BITS-1:0] nlen_r, nlen_nxt;
  logic [PIDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]    cur_r, cur_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [SUM_W-1:0]    hit_cur_r, hit_cur_nxt;
  piece_t              hp_r, hp_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    sh_at_r, sh_at_nxt;
  logic [1:0]          sh_n_r, sh_n_nxt;
  logic [IDX_W-1:0]    fx_at_r, fx_at_nxt;
  logic [1:0]          fx_cnt_r, fx_cnt_nxt;
  logic [1:0]          fx_step_r, fx_step_nxt;
  piece_t              fx_e_r [3];
  piece_t              fx_e_nxt [3];
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  piece_t              out_p_r, out_p_nxt;

  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  piece_t              wr_data;
  logic [$bits(piece_t)-1:0] rd_raw;
  piece_t              rd_p;

  pte_ram #(.WIDTH($bits(piece_t)), .DEPTH(MAX_PIECES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_p = piece_t'(rd_raw);

  // Per-entry arithmetic on the piece that has just come out of the RAM.
  logic [SUM_W-1:0]    pos_w, end_w, pe, lo, hi;
  logic                ins_hit, touched, rem_split;
  logic [POS_BITS-1:0] cut_left, cut_rl;
  piece_t              left_p, right_p;

  always_comb begin
    pos_w     = SUM_W'(pos_r);
    end_w     = SUM_W'(pos_r) + SUM_W'(nlen_r);
    pe        = cur_r + SUM_W'(rd_p.len);
    ins_hit   = (pos_w >= cur_r) && (pos_w <= pe);
    lo        = (cur_r > pos_w) ? cur_r : pos_w;
    hi        = (pe < end_w) ? pe : end_w;
    touched   = lo < hi;
    rem_split = touched && (pos_w > cur_r) && (pe > end_w);
    cut_left  = POS_BITS'(pos_w - cur_r);
    cut_rl    = POS_BITS'(pe - end_w);
    left_p    = '{kind: rd_p.kind, start: rd_p.start, len: cut_left};
    right_p   = '{kind: rd_p.kind, start: rd_p.start + (rd_p.len - cut_rl), len: cut_rl};
  end

  // Arithmetic on the recorded piece, used when deciding an edit.
  logic [SUM_W-1:0]    hpe;
  logic [POS_BITS:0]   msum, mend;
  logic [POS_BITS-1:0] h_left, h_rl;
  piece_t              np;

  always_comb begin
    hpe    = hit_cur_r + SUM_W'(hp_r.len);
    msum   = {1'b0, hp_r.len} + {1'b0, nlen_r};
    mend   = {1'b0, hp_r.start} + {1'b0, hp_r.len};
    h_left = POS_BITS'(pos_w - hit_cur_r);
    h_rl   = POS_BITS'(hpe - end_w);
    np     = '{kind: kind_r, start: nstart_r, len: nlen_r};
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    kind_nxt       = kind_r;
    nstart_nxt     = nstart_r;
    nlen_nxt       = nlen_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = 1'b0;
    cur_nxt        = cur_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_cur_nxt    = hit_cur_r;
    hp_nxt         = hp_r;
    k_nxt          = k_r;
    sh_at_nxt      = sh_at_r;
    sh_n_nxt       = sh_n_r;
    fx_at_nxt      = fx_at_r;
    fx_cnt_nxt     = fx_cnt_r;
    fx_step_nxt    = fx_step_r;
    fx_e_nxt       = fx_e_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_p_nxt      = out_p_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rd_p;
    rd_en          = 1'b0;
    rd_addr        = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt     = in_req_type;
          pos_nxt    = in_doc_position;
          kind_nxt   = in_buffer_kind;
          nstart_nxt = in_piece_start;
          nlen_nxt   = in_run_length;
          idx_nxt    = in_piece_index;
          iss_nxt    = '0;
          cur_nxt    = '0;
          hit_nxt    = 1'b0;
          out_p_nxt  = '0;
          case (in_req_type)
            REQ_INSERT, REQ_REMOVE: state_nxt = ST_SCAN;
            REQ_READ:               state_nxt = ST_RD_ISSUE;
            default: begin
              out_status_nxt = STAT_OK;
              out_valid_nxt  = 1'b1;
            end
          endcase
        end
      end

      ST_RD_ISSUE: begin
        if (CNT_W'(idx_r) < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(idx_r);
          state_nxt = ST_RD_DATA;
        end else begin
          out_status_nxt = STAT_BADIDX;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_RD_DATA: begin
        out_p_nxt      = rd_p;
        out_status_nxt = STAT_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_SCAN: begin
        if (rd_vld_r) begin
          cur_nxt = pe;
          if ((op_r == REQ_INSERT && ins_hit) || (op_r == REQ_REMOVE && rem_split)) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
            hit_cur_nxt = cur_r;
            hp_nxt      = rd_p;
          end
        end
        if (rd_vld_r && op_r == REQ_INSERT && ins_hit) begin
          // Covering piece found: stop issuing, nothing further is in flight.
          state_nxt = ST_DECIDE;
        end else if (iss_r < count_r) begin
          rd_en      = 1'b1;
          rd_addr    = IDX_W'(iss_r);
          rd_idx_nxt = IDX_W'(iss_r);
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        fx_step_nxt = '0;
        iss_nxt     = count_r;
        sh_at_nxt   = count_r;
        sh_n_nxt    = 2'd0;
        if (op_r == REQ_INSERT) begin
          if (count_r == '0) begin
            if (pos_r == '0) begin
              fx_at_nxt   = '0;
              fx_e_nxt[0] = np;
              fx_cnt_nxt  = 2'd1;
              state_nxt   = ST_FIX;
            end else begin
              out_status_nxt = STAT_RANGE;
              out_valid_nxt  = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end else if (!hit_r) begin
            out_status_nxt = STAT_RANGE;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end else if (pos_w == hit_cur_r) begin
            if (count_r >= CNT_W'(MAX_PIECES)) begin
              out_status_nxt = STAT_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = ST_IDLE;
            end else begin
              sh_at_nxt   = CNT_W'(hit_idx_r);
              sh_n_nxt    = 2'd1;
              fx_at_nxt   = hit_idx_r;
              fx_e_nxt[0] = np;
              fx_cnt_nxt  = 2'd1;
              state_nxt   = ST_SHIFT;
            end
          end else if (pos_w == hpe) begin
            if (kind_r == hp_r.kind && mend == {1'b0, nstart_r} && !msum[POS_BITS]) begin
              fx_at_nxt   = hit_idx_r;
              fx_e_nxt[0] = '{kind: hp_r.kind, start: hp_r.start, len: msum[POS_BITS-1:0]};
              fx_cnt_nxt  = 2'd1;
              state_nxt   = ST_FIX;
            end else if (count_r >= CNT_W'(MAX_PIECES)) begin
              out_status_nxt = STAT_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = ST_IDLE;
            end else begin
              sh_at_nxt   = CNT_W'(hit_idx_r) + 1'b1;
              sh_n_nxt    = 2'd1;
              fx_at_nxt   = hit_idx_r + 1'b1;
              fx_e_nxt[0] = np;
              fx_cnt_nxt  = 2'd1;
              state_nxt   = ST_SHIFT;
            end
          end else begin
            if (count_r + 2'd2 > CNT_W'(MAX_PIECES)) begin
              out_status_nxt = STAT_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = ST_IDLE;
            end else begin
              sh_at_nxt   = CNT_W'(hit_idx_r) + 1'b1;
              sh_n_nxt    = 2'd2;
              fx_at_nxt   = hit_idx_r;
              fx_e_nxt[0] = '{kind: hp_r.kind, start: hp_r.start, len: h_left};
              fx_e_nxt[1] = np;
              fx_e_nxt[2] = '{kind: hp_r.kind, start: hp_r.start + h_left,
                              len: hp_r.len - h_left};
              fx_cnt_nxt  = 2'd3;
              state_nxt   = ST_SHIFT;
            end
          end
        end else begin
          // Remove: cur_r now holds the document length.
          if (nlen_r == '0) begin
            out_status_nxt = STAT_OK;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end else if (end_w > cur_r) begin
            out_status_nxt = STAT_RANGE;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end else if (hit_r) begin
            if (count_r >= CNT_W'(MAX_PIECES)) begin
              out_status_nxt = STAT_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = ST_IDLE;
            end else begin
              sh_at_nxt   = CNT_W'(hit_idx_r) + 1'b1;
              sh_n_nxt    = 2'd1;
              fx_at_nxt   = hit_idx_r;
              fx_e_nxt[0] = '{kind: hp_r.kind, start: hp_r.start, len: h_left};
              fx_e_nxt[1] = '{kind: hp_r.kind, start: hp_r.start + (hp_r.len - h_rl),
                              len: h_rl};
              fx_cnt_nxt  = 2'd2;
              state_nxt   = ST_SHIFT;
            end
          end else begin
            iss_nxt   = '0;
            cur_nxt   = '0;
            k_nxt     = '0;
            state_nxt = ST_COMPACT;
          end
        end
      end

      ST_SHIFT: begin
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_r + IDX_W'(sh_n_r);
          wr_data = rd_p;
        end
        if (iss_r > sh_at_r) begin
          rd_en      = 1'b1;
          rd_addr    = IDX_W'(iss_r - 1'b1);
          rd_idx_nxt = IDX_W'(iss_r - 1'b1);
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r - 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_FIX;
        end
      end

      ST_FIX: begin
        wr_en       = 1'b1;
        wr_addr     = fx_at_r + IDX_W'(fx_step_r);
        wr_data     = fx_e_r[fx_step_r];
        fx_step_nxt = fx_step_r + 1'b1;
        if (fx_step_r == fx_cnt_r - 1'b1) begin
          // Growth is the number of slots opened by the shift, or one for an
          // insert into an empty table.
          count_nxt      = count_r + CNT_W'(sh_n_r) + CNT_W'(count_r == '0);
          out_status_nxt = STAT_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_COMPACT: begin
        if (rd_vld_r) begin
          cur_nxt = pe;
          wr_addr = IDX_W'(k_r);
          if (!touched) begin
            wr_en   = 1'b1;
            wr_data = rd_p;
            k_nxt   = k_r + 1'b1;
          end else if (pos_w > cur_r) begin
            wr_en   = 1'b1;
            wr_data = left_p;
            k_nxt   = k_r + 1'b1;
          end else if (pe > end_w) begin
            wr_en   = 1'b1;
            wr_data = right_p;
            k_nxt   = k_r + 1'b1;
          end
        end
        if (iss_r < count_r) begin
          rd_en      = 1'b1;
          rd_addr    = IDX_W'(iss_r);
          rd_idx_nxt = IDX_W'(iss_r);
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r + 1'b1;
        end else if (!rd_vld_r) begin
          count_nxt      = k_r;
          out_status_nxt = STAT_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    kind_r       <= kind_nxt;
    nstart_r     <= nstart_nxt;
    nlen_r       <= nlen_nxt;
    idx_r        <= idx_nxt;
    iss_r        <= iss_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cur_r        <= cur_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_cur_r    <= hit_cur_nxt;
    hp_r         <= hp_nxt;
    k_r          <= k_nxt;
    sh_at_r      <= sh_at_nxt;
    sh_n_r       <= sh_n_nxt;
    fx_at_r      <= fx_at_nxt;
    fx_cnt_r     <= fx_cnt_nxt;
    fx_step_r    <= fx_step_nxt;
    fx_e_r       <= fx_e_nxt;
    out_status_r <= out_status_nxt;
    out_p_r      <= out_p_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_piece_total = count_r;
  assign out_kind        = out_p_r.kind;
  assign out_start       = out_p_r.start;
  assign out_length      = out_p_r.len;

  `PTE_ASSERT_NEXT(a_start_busy, start && !busy, busy || out_valid_r, "accepted request lost")
  `PTE_ASSERT_NOW(a_count_max, 1'b1, count_r <= CNT_W'(MAX_PIECES), "piece count overflow")
  `PTE_ASSERT_NOW(a_idle_nowrite, state_r == ST_IDLE, !wr_en, "table written while idle")
  `PTE_ASSERT_NOW(a_beat_idle, out_valid_r, state_r == ST_IDLE, "result beat while still busy")
  `PTE_ASSERT_NOW(a_rd_tag, rd_vld_r, state_r != ST_IDLE, "read data returned while idle")

endmodule
